// ===== rtl/core/fksc_pkg.sv =====
// fksc_pkg: shared types and constants of the flow key support counter
// depends on nothing; used by flow_key_support_counter and its bench
package fksc_pkg;

   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] FIRST_SID_RESET = 32'd1000000;
   localparam logic [31:0] MIN_SUPPORT_RESET = 32'd3;

   // configuration register indexes
   localparam logic [1:0] REG_MIN_SUPPORT = 2'd0;
   localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_FIRST_SID = 2'd2;

   // result outcome codes
   localparam logic [1:0] OUTCOME_HIT = 2'd0;
   localparam logic [1:0] OUTCOME_FILL = 2'd1;
   localparam logic [1:0] OUTCOME_EVICT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] count;
      logic [31:0] seen_time;
      logic        emitted;
      logic [31:0] sid;
   } entry_type;

endpackage

// ===== rtl/core/fksc_ram.sv =====
// fksc_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
module fksc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/flow_key_support_counter.sv =====
// flow_key_support_counter: associative flow key table with support counting
// depends on fksc_pkg and fksc_ram
// a request on an empty table goes straight to the update; else the key search reads one table
// entry per cycle over the slots in use, stopping at a key match, through the single ram read port,
// so the next word is taken in the result cycle.
// reset (synchronous) empties the table by its fill count and restores register defaults;
// the receiver cannot stall and takes each result in its one strobe cycle.
module flow_key_support_counter
   import fksc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_proto,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_tcp_flags,
   input  logic [15:0] req_ml_score,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   output logic        rsp_emitted,
   output logic [31:0] rsp_sid,
   output logic [7:0]  rsp_slot,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_entry_count,
   output logic [7:0]  rsp_rule_proto,
   output logic [15:0] rsp_rule_port,
   output logic [7:0]  rsp_rule_flags,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int FW = IW + 1;
   localparam logic [FW-1:0] FULL_COUNT = FW'(TABLE_ENTRIES);

   state_type state_ff, state_in;

   logic [31:0] min_support_ff;
   logic [15:0] score_threshold_ff;
   logic [31:0] next_sid_ff;
   logic [FW-1:0] fill_ff, fill_in;

   logic [7:0]  proto_ff;
   logic [15:0] port_ff;
   logic [7:0]  flags_ff;
   logic [15:0] score_ff;
   logic [31:0] now_ff;

   logic [FW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [31:0]   min_ff, min_in;
   logic [IW-1:0] min_idx_ff, min_idx_in;

   logic [IW-1:0] slot_ff, slot_in;
   logic [1:0]    outcome_ff, outcome_in;
   logic [31:0]   hold_count_ff, hold_count_in;
   logic          hold_em_ff, hold_em_in;
   logic [31:0]   hold_sid_ff, hold_sid_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_emitted_ff;
   logic [31:0] rsp_sid_ff;
   logic [7:0]  rsp_slot_ff;
   logic [1:0]  rsp_outcome_ff;
   logic [31:0] rsp_count_ff;

   logic          accept;
   logic [7:0]    norm_port_hi;
   logic [15:0]   norm_port;
   logic [7:0]    norm_flags;
   logic [31:0]   key;
   logic          issue;
   logic [IW-1:0] rd_addr;
   entry_type     rd_entry;
   logic [FW-1:0] last_idx;
   logic          cur_is_min;
   logic [IW-1:0] cur_min_idx;
   logic          wr_en;
   entry_type     wr_entry;
   logic [31:0]   count_new;
   logic          fire;
   logic [31:0]   sid_new;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   // key normalization at the input
   always_comb begin
      norm_port = (req_proto == PROTO_TCP || req_proto == PROTO_UDP) ? req_dest_port : 16'd0;
      norm_flags = (req_proto == PROTO_TCP) ? req_tcp_flags : 8'd0;
      norm_port_hi = norm_port[15:8];
   end

   assign key = {proto_ff, port_ff, flags_ff};

   fksc_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // scan control: one read issued per cycle over the filled slots
   assign issue = (state_ff == ST_SCAN) && (scan_ff < fill_ff);
   assign rd_addr = scan_ff[IW-1:0];
   assign last_idx = fill_ff - FW'(1);
   assign cur_is_min = (pidx_ff == '0) || (rd_entry.seen_time < min_ff);
   assign cur_min_idx = cur_is_min ? pidx_ff : min_idx_ff;

   // entry update for the chosen slot
   always_comb begin
      if (outcome_ff == OUTCOME_HIT) begin
         count_new = (hold_count_ff == COUNT_MAX) ? COUNT_MAX : hold_count_ff + 32'd1;
      end else begin
         count_new = 32'd1;
      end
      fire = !hold_em_ff && (score_ff >= score_threshold_ff) && (count_new >= min_support_ff);
      sid_new = fire ? next_sid_ff : hold_sid_ff;
      wr_en = (state_ff == ST_UPDATE);
      wr_entry.key = key;
      wr_entry.count = count_new;
      wr_entry.seen_time = now_ff;
      wr_entry.emitted = hold_em_ff || fire;
      wr_entry.sid = sid_new;
   end

   // next state and search bookkeeping
   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      pend_in = 1'b0;
      pidx_in = rd_addr;
      min_in = min_ff;
      min_idx_in = min_idx_ff;
      slot_in = slot_ff;
      outcome_in = outcome_ff;
      hold_count_in = hold_count_ff;
      hold_em_in = hold_em_ff;
      hold_sid_in = hold_sid_ff;
      fill_in = fill_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (accept) begin
               hold_count_in = 32'd0;
               hold_em_in = 1'b0;
               hold_sid_in = 32'd0;
               if (fill_ff == '0) begin
                  slot_in = '0;
                  outcome_in = OUTCOME_FILL;
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + FW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (cur_is_min) begin
                  min_in = rd_entry.seen_time;
                  min_idx_in = pidx_ff;
               end
               if (rd_entry.key == key) begin
                  slot_in = pidx_ff;
                  outcome_in = OUTCOME_HIT;
                  hold_count_in = rd_entry.count;
                  hold_em_in = rd_entry.emitted;
                  hold_sid_in = rd_entry.sid;
                  pend_in = 1'b0;
                  state_in = ST_UPDATE;
               end else if (FW'(pidx_ff) == last_idx) begin
                  if (fill_ff == FULL_COUNT) begin
                     slot_in = cur_min_idx;
                     outcome_in = OUTCOME_EVICT;
                  end else begin
                     slot_in = fill_ff[IW-1:0];
                     outcome_in = OUTCOME_FILL;
                  end
                  pend_in = 1'b0;
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (outcome_ff == OUTCOME_FILL) begin
               fill_in = fill_ff + FW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_support_ff <= MIN_SUPPORT_RESET;
         score_threshold_ff <= 16'd0;
         next_sid_ff <= FIRST_SID_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_UPDATE && fire) begin
            next_sid_ff <= next_sid_ff + 32'd1;
         end
         if (csr_we) begin
            case (csr_index)
               REG_MIN_SUPPORT:     min_support_ff <= csr_wdata;
               REG_SCORE_THRESHOLD: score_threshold_ff <= csr_wdata[15:0];
               REG_FIRST_SID:       next_sid_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         proto_ff <= req_proto;
         port_ff <= {norm_port_hi, norm_port[7:0]};
         flags_ff <= norm_flags;
         score_ff <= req_ml_score;
         now_ff <= req_now_time;
      end
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      min_ff <= min_in;
      min_idx_ff <= min_idx_in;
      slot_ff <= slot_in;
      outcome_ff <= outcome_in;
      hold_count_ff <= hold_count_in;
      hold_em_ff <= hold_em_in;
      hold_sid_ff <= hold_sid_in;
      if (state_ff == ST_UPDATE) begin
         rsp_emitted_ff <= fire;
         rsp_sid_ff <= sid_new;
         rsp_slot_ff <= 8'(slot_ff);
         rsp_outcome_ff <= outcome_ff;
         rsp_count_ff <= count_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_emitted = rsp_emitted_ff;
   assign rsp_sid = rsp_sid_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_rule_proto = proto_ff;
   assign rsp_rule_port = port_ff;
   assign rsp_rule_flags = flags_ff;

endmodule

// ===== bench/flow_key_support_counter_tb.sv =====
// flow_key_support_counter_tb: self-checking bench for the flow key support counter
// depends on fksc_pkg and flow_key_support_counter; predicts every result word in-bench
`timescale 1ns / 1ps

module flow_key_support_counter_tb
   import fksc_pkg::*;
;

   localparam int SLOTS = 256;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_proto;
   logic [15:0] req_dest_port;
   logic [7:0]  req_tcp_flags;
   logic [15:0] req_ml_score;
   logic [31:0] req_now_time;
   logic        rsp_valid;
   logic        rsp_emitted;
   logic [31:0] rsp_sid;
   logic [7:0]  rsp_slot;
   logic [1:0]  rsp_outcome;
   logic [31:0] rsp_entry_count;
   logic [7:0]  rsp_rule_proto;
   logic [15:0] rsp_rule_port;
   logic [7:0]  rsp_rule_flags;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   typedef struct packed {
      logic        emitted;
      logic [31:0] sid;
      logic [7:0]  slot;
      logic [1:0]  outcome;
      logic [31:0] count;
      logic [7:0]  proto;
      logic [15:0] port;
      logic [7:0]  flags;
   } verdict_type;

   // predictor state
   logic        tbl_valid [SLOTS];
   entry_type   tbl_entry [SLOTS];
   logic [31:0] cfg_min_support;
   logic [15:0] cfg_threshold;
   logic [31:0] sid_next;

   verdict_type verdict_queue[$];
   int          error_count;
   int          word_count;
   int          emit_count;
   int          evict_count;
   bit          idle_enable;

   flow_key_support_counter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("flow_key_support_counter_tb NOT OK");
      $finish;
   end

   // predictor: one observation in, one expected result out
   function automatic verdict_type predict_observation(logic [7:0] proto, logic [15:0] port,
         logic [7:0] flags, logic [15:0] score, logic [31:0] now);
      verdict_type v;
      logic [31:0] key;
      int          s;
      int          best;
      logic [1:0]  oc;
      if (proto != PROTO_TCP && proto != PROTO_UDP) port = '0;
      if (proto != PROTO_TCP) flags = '0;
      key = {proto, port, flags};
      s = -1;
      oc = OUTCOME_HIT;
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && tbl_valid[i] && tbl_entry[i].key == key) s = i;
      if (s < 0) begin
         oc = OUTCOME_FILL;
         for (int i = 0; i < SLOTS; i++)
            if (s < 0 && !tbl_valid[i]) s = i;
      end
      if (s < 0) begin
         oc = OUTCOME_EVICT;
         best = 0;
         for (int i = 1; i < SLOTS; i++)
            if (tbl_entry[i].seen_time < tbl_entry[best].seen_time) best = i;
         s = best;
      end
      if (oc != OUTCOME_HIT) begin
         tbl_valid[s] = 1'b1;
         tbl_entry[s] = '0;
         tbl_entry[s].key = key;
      end
      if (tbl_entry[s].count != COUNT_MAX) tbl_entry[s].count++;
      tbl_entry[s].seen_time = now;
      v.emitted = 1'b0;
      if (!tbl_entry[s].emitted && score >= cfg_threshold
            && tbl_entry[s].count >= cfg_min_support) begin
         tbl_entry[s].sid = sid_next;
         tbl_entry[s].emitted = 1'b1;
         sid_next++;
         v.emitted = 1'b1;
      end
      v.sid = tbl_entry[s].sid;
      v.slot = s[7:0];
      v.outcome = oc;
      v.count = tbl_entry[s].count;
      v.proto = proto;
      v.port = port;
      v.flags = flags;
      return v;
   endfunction

   // result checker
   initial begin
      verdict_type v;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid) begin
            if (verdict_queue.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               v = verdict_queue.pop_front();
               if (rsp_emitted !== v.emitted) begin
                  $error("emitted exp %0d got %0d", v.emitted, rsp_emitted); error_count++;
               end
               if (rsp_sid !== v.sid) begin
                  $error("sid exp %0d got %0d", v.sid, rsp_sid); error_count++;
               end
               if (rsp_slot !== v.slot) begin
                  $error("slot exp %0d got %0d", v.slot, rsp_slot); error_count++;
               end
               if (rsp_outcome !== v.outcome) begin
                  $error("outcome exp %0d got %0d", v.outcome, rsp_outcome); error_count++;
               end
               if (rsp_entry_count !== v.count) begin
                  $error("entry_count exp %0d got %0d", v.count, rsp_entry_count);
                  error_count++;
               end
               if (rsp_rule_proto !== v.proto) begin
                  $error("rule_proto exp %0d got %0d", v.proto, rsp_rule_proto); error_count++;
               end
               if (rsp_rule_port !== v.port) begin
                  $error("rule_port exp %0d got %0d", v.port, rsp_rule_port); error_count++;
               end
               if (rsp_rule_flags !== v.flags) begin
                  $error("rule_flags exp %0d got %0d", v.flags, rsp_rule_flags);
                  error_count++;
               end
               if (v.emitted) emit_count++;
               if (v.outcome == OUTCOME_EVICT) evict_count++;
            end
         end
      end
   end

   // send one observation word; waits for busy low
   task automatic send_word(logic [7:0] proto, logic [15:0] port, logic [7:0] flags,
         logic [15:0] score, logic [31:0] now);
      verdict_type v;
      if (idle_enable) begin
         while ($urandom_range(99) < 7) @(negedge clock);
      end
      while (busy) @(negedge clock);
      start = 1'b1;
      req_proto = proto;
      req_dest_port = port;
      req_tcp_flags = flags;
      req_ml_score = score;
      req_now_time = now;
      v = predict_observation(proto, port, flags, score, now);
      verdict_queue.push_back(v);
      word_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // wait for all results, then let the block settle
   task automatic drain;
      int guard;
      guard = 0;
      while (verdict_queue.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SLOTS + 10) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         REG_MIN_SUPPORT: cfg_min_support = value;
         REG_SCORE_THRESHOLD: cfg_threshold = value[15:0];
         REG_FIRST_SID: sid_next = value;
         default: ;
      endcase
   endtask

   // random key drawn from a small pool so hits, emits and evictions all happen
   task automatic send_random(int key_span);
      logic [7:0] proto;
      case ($urandom_range(3))
         0: proto = PROTO_TCP;
         1: proto = PROTO_UDP;
         2: proto = 8'd1;
         default: proto = 8'($urandom);
      endcase
      send_word(proto, 16'($urandom_range(key_span)), 8'($urandom_range(key_span) * 37),
         16'($urandom), $urandom);
   endtask

   // directed: field extremes, normalization, thresholds
   task automatic test_directed;
      send_word(PROTO_TCP, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(PROTO_TCP, 16'hFFFF, 8'hFF, 16'h0000, 32'd0);
      send_word(PROTO_TCP, 16'hFFFF, 8'hFF, 16'h0000, 32'd5);
      send_word(PROTO_TCP, 16'hFFFF, 8'hFF, 16'h0000, 32'd6);
      send_word(PROTO_UDP, 16'h1234, 8'hAA, 16'h8000, 32'd7);
      send_word(8'd1, 16'h5555, 8'h55, 16'h0, 32'd8);
      send_word(8'd1, 16'hAAAA, 8'hAA, 16'h0, 32'd9);
      send_word(8'hFF, 16'h0, 8'h0, 16'hFFFF, 32'd10);
      send_word(8'h00, 16'hFFFF, 8'hFF, 16'h0, 32'd11);
      drain();
      write_register(REG_MIN_SUPPORT, 32'd0);
      write_register(REG_SCORE_THRESHOLD, 32'h0000_FFFF);
      write_register(REG_FIRST_SID, 32'hFFFF_FFFE);
      send_word(8'd2, 16'd0, 8'd0, 16'hFFFE, 32'd12);
      send_word(8'd2, 16'd0, 8'd0, 16'hFFFF, 32'd13);
      send_word(8'd3, 16'd0, 8'd0, 16'hFFFF, 32'd14);
      send_word(8'd4, 16'd0, 8'd0, 16'hFFFF, 32'd15);
      drain();
      write_register(REG_MIN_SUPPORT, 32'hFFFF_FFFF);
      write_register(REG_SCORE_THRESHOLD, 32'd0);
      send_word(8'd4, 16'd0, 8'd0, 16'h0, 32'd16);
      drain();
   endtask

   // fill the whole table, then evict with timestamps and ties
   task automatic test_eviction;
      write_register(REG_MIN_SUPPORT, 32'd2);
      write_register(REG_FIRST_SID, $urandom);
      for (int i = 0; i < SLOTS; i++)
         send_word(PROTO_UDP, 16'(16'h4000 + i), 8'd0, 16'($urandom),
            (i % 5 == 0) ? 32'd3 : 32'd100 + i);
      for (int i = 0; i < 20; i++)
         send_word(PROTO_UDP, 16'(16'h8000 + i), 8'd0, 16'($urandom), 32'd3);
      drain();
   endtask

   // random traffic with idling, a quiet stretch and a full pause
   task automatic test_random;
      write_register(REG_MIN_SUPPORT, 32'd4);
      write_register(REG_SCORE_THRESHOLD, 32'h0000_4000);
      write_register(REG_FIRST_SID, 32'd42);
      idle_enable = 1'b1;
      for (int i = 0; i < 300; i++) send_random(15);
      drain();
      write_register(REG_MIN_SUPPORT, 32'd1);
      write_register(REG_SCORE_THRESHOLD, 32'd0);
      idle_enable = 1'b0;
      for (int i = 0; i < 150; i++) send_random(255);
      drain();
      idle_enable = 1'b1;
      for (int i = 0; i < 150; i++) send_random(7);
      drain();
   endtask

   initial begin
      error_count = 0;
      word_count = 0;
      emit_count = 0;
      evict_count = 0;
      idle_enable = 1'b0;
      start = 1'b0;
      req_proto = '0;
      req_dest_port = '0;
      req_tcp_flags = '0;
      req_ml_score = '0;
      req_now_time = '0;
      csr_we = 1'b0;
      csr_index = REG_MIN_SUPPORT;
      csr_wdata = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_entry[i] = '0;
      end
      cfg_min_support = MIN_SUPPORT_RESET;
      cfg_threshold = '0;
      sid_next = FIRST_SID_RESET;
      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      repeat (SLOTS + 10) @(negedge clock);
      test_directed();
      test_eviction();
      test_random();
      $display("covered %0d words: %0d emits, %0d evictions, several register settings",
         word_count, emit_count, evict_count);
      if (error_count == 0 && verdict_queue.size() == 0)
         $display("flow_key_support_counter_tb OK");
      else
         $display("flow_key_support_counter_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fksc_pkg.sv
rtl/core/fksc_ram.sv
rtl/core/flow_key_support_counter.sv
bench/flow_key_support_counter_tb.sv
